[sv/mm4_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mm4_pkg
// Shared sizes, command codes and controller/datapath interface types for
// the Q16.16 square matrix multiplier.
// ----------------------------------------------------------------------------
package mm4_pkg;

	localparam int DIM    = 4;
	localparam int CELLS  = DIM * DIM;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int K_W    = (DIM > 1) ? $clog2(DIM) : 1;
	localparam int VAL_W  = 32;
	localparam int IDX_W  = 4;
	localparam int CMD_W  = 2;
	localparam int PROD_W = 2 * VAL_W;
	localparam int FRAC_W = 16;
	// shifted product is PROD_W - FRAC_W bits; DIM terms need K_W more, plus one spare
	localparam int ACC_W  = PROD_W - FRAC_W + K_W + 1;

	localparam logic [CMD_W-1:0] CMD_LOAD_LEFT  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LOAD_RIGHT = 2'd1;
	localparam logic [CMD_W-1:0] CMD_COMPUTE    = 2'd2;

	typedef struct packed {
		logic load_l;
		logic load_r;
		logic start;
		logic issue;
		logic emit;
	} mm4_cmd_t;

	typedef struct packed {
		logic k_last;
		logic e_last;
		logic acc_done;
		logic out_free;
	} mm4_stat_t;

endpackage
`default_nettype wire

[sv/matrix_4x4_multiply_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// matrix_4x4_multiply_top
// Square matrix product in signed Q16.16, both matrices in column-major order.
// ----------------------------------------------------------------------------
// Load requests produce no result and can be taken back to back while idle.
// A compute request produces DIM*DIM results. For each, the sequencer issues
// its multiply-accumulate terms over k, lets the read/multiply/accumulate
// pipeline drain and moves the saturated sum into the output register once
// that has room; the next element starts only then. Input is held off meanwhile.
// Reset (arst_n low) clears both matrices to zero via per-entry valid bits.
// ----------------------------------------------------------------------------
module matrix_4x4_multiply_top (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// request channel
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic [mm4_pkg::CMD_W-1:0]          command,
	input  wire logic [mm4_pkg::IDX_W-1:0]          element_index,
	input  wire logic signed [mm4_pkg::VAL_W-1:0]   element_value,
	// result channel
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic [mm4_pkg::IDX_W-1:0]               product_index,
	output logic signed [mm4_pkg::VAL_W-1:0]        product_value,
	output logic                                    last
);

	// command and status between sequencer and datapath
	mm4_pkg::mm4_cmd_t  cmd;
	mm4_pkg::mm4_stat_t stat;

	// sequencer: holds off requests while a compute runs, paces the
	// per-element multiply-accumulate and waits for room at the output
	mm4_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.command  (command),
		.stat     (stat),
		.cmd      (cmd)
	);

	// datapath: matrix stores, one multiply per cycle while terms issue,
	// wide accumulate, saturate, and the output register that lets loads
	// proceed while the final result waits to be taken
	mm4_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.element_index (element_index),
		.element_value (element_value),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.product_index (product_index),
		.product_value (product_value),
		.last          (last)
	);

endmodule
`default_nettype wire

[sv/mm4_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mm4_ctrl
// Sequencer: takes requests, steps the multiply-accumulate over k for each
// product element and hands finished sums to the output register.
// ----------------------------------------------------------------------------
module mm4_ctrl (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [mm4_pkg::CMD_W-1:0]     command,
	input  wire mm4_pkg::mm4_stat_t            stat,
	output mm4_pkg::mm4_cmd_t                  cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_MAC,
		S_WAIT
	} state_t;

	state_t state_q;
	logic   in_ready_q;
	logic   accept;

	assign in_ready = in_ready_q;
	assign accept   = in_valid && in_ready_q;

	always_comb begin
		cmd        = '0;
		cmd.load_l = accept && (command == mm4_pkg::CMD_LOAD_LEFT);
		cmd.load_r = accept && (command == mm4_pkg::CMD_LOAD_RIGHT);
		cmd.start  = accept && (command == mm4_pkg::CMD_COMPUTE);
		cmd.issue  = (state_q == S_MAC);
		cmd.emit   = (state_q == S_WAIT) && stat.acc_done && stat.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			in_ready_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd.start) begin
						in_ready_q <= 1'b0;
						state_q    <= S_MAC;
					end else begin
						in_ready_q <= 1'b1;
					end
				end
				S_MAC: begin
					if (stat.k_last) begin
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					if (cmd.emit) begin
						if (stat.e_last) begin
							in_ready_q <= 1'b1;
							state_q    <= S_IDLE;
						end else begin
							state_q <= S_MAC;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

[sv/mm4_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mm4_datapath
// Matrix stores, element counters, read/multiply/accumulate pipeline,
// saturation and the output register.
// ----------------------------------------------------------------------------
module mm4_datapath (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire mm4_pkg::mm4_cmd_t                  cmd,
	output mm4_pkg::mm4_stat_t                      stat,
	input  wire logic [mm4_pkg::IDX_W-1:0]          element_index,
	input  wire logic signed [mm4_pkg::VAL_W-1:0]   element_value,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic [mm4_pkg::IDX_W-1:0]               product_index,
	output logic signed [mm4_pkg::VAL_W-1:0]        product_value,
	output logic                                    last
);

	localparam int ADDR_W = mm4_pkg::ADDR_W;
	localparam int K_W    = mm4_pkg::K_W;
	localparam int VAL_W  = mm4_pkg::VAL_W;
	localparam int ACC_W  = mm4_pkg::ACC_W;
	localparam int SH_W   = mm4_pkg::PROD_W - mm4_pkg::FRAC_W;

	localparam logic signed [ACC_W-1:0] SAT_MAX =
		ACC_W'(signed'({1'b0, {(VAL_W-1){1'b1}}}));
	localparam logic signed [ACC_W-1:0] SAT_MIN =
		ACC_W'(signed'({1'b1, {(VAL_W-1){1'b0}}}));

	logic [VAL_W-1:0]              mem_l [mm4_pkg::CELLS];
	logic [VAL_W-1:0]              mem_r [mm4_pkg::CELLS];
	logic [mm4_pkg::CELLS-1:0]     vl_q;
	logic [mm4_pkg::CELLS-1:0]     vr_q;

	logic [31:0]                   idx_wide;
	logic [ADDR_W-1:0]             wr_addr;
	logic                          wr_ok;

	logic [K_W-1:0]                k_q, r_q, c_q;
	logic [ADDR_W-1:0]             e_q;
	logic                          k_last, r_last, e_last;
	logic [ADDR_W-1:0]             ra_l, ra_r;
	logic [31:0]                   e_wide;

	logic [VAL_W-1:0]              rd_l_s1, rd_r_s1;
	logic                          rdv_l_s1, rdv_r_s1;
	logic                          valid_s1, first_s1, lastk_s1;
	logic signed [VAL_W-1:0]       opl, opr;

	logic signed [mm4_pkg::PROD_W-1:0] prod_s2;
	logic                          valid_s2, first_s2, lastk_s2;
	logic signed [mm4_pkg::PROD_W-1:0] prod_sh;
	logic signed [ACC_W-1:0]       term;

	logic signed [ACC_W-1:0]       acc_q;
	logic                          acc_done_q;
	logic signed [VAL_W-1:0]       sat_val;

	logic                          out_valid_q;
	logic [mm4_pkg::IDX_W-1:0]     out_idx_q;
	logic signed [VAL_W-1:0]       out_val_q;
	logic                          out_last_q;

	// load address, ignoring positions past the end of the store
	assign idx_wide = {{(32-mm4_pkg::IDX_W){1'b0}}, element_index};
	assign wr_addr  = idx_wide[ADDR_W-1:0];
	assign wr_ok    = idx_wide < 32'(mm4_pkg::CELLS);

	assign k_last = (k_q == K_W'(mm4_pkg::DIM - 1));
	assign r_last = (r_q == K_W'(mm4_pkg::DIM - 1));
	assign e_last = (e_q == ADDR_W'(mm4_pkg::CELLS - 1));
	assign ra_l   = ADDR_W'(32'(k_q) * mm4_pkg::DIM + 32'(r_q));
	assign ra_r   = ADDR_W'(32'(c_q) * mm4_pkg::DIM + 32'(k_q));
	assign e_wide = 32'(e_q);

	always_ff @(posedge clk) begin
		if (cmd.load_l && wr_ok) begin
			mem_l[wr_addr] <= element_value;
		end
		if (cmd.load_r && wr_ok) begin
			mem_r[wr_addr] <= element_value;
		end
		if (cmd.issue) begin
			rd_l_s1 <= mem_l[ra_l];
			rd_r_s1 <= mem_r[ra_r];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vl_q     <= '0;
			vr_q     <= '0;
			rdv_l_s1 <= 1'b0;
			rdv_r_s1 <= 1'b0;
		end else begin
			if (cmd.load_l && wr_ok) begin
				vl_q[wr_addr] <= 1'b1;
			end
			if (cmd.load_r && wr_ok) begin
				vr_q[wr_addr] <= 1'b1;
			end
			if (cmd.issue) begin
				rdv_l_s1 <= vl_q[ra_l];
				rdv_r_s1 <= vr_q[ra_r];
			end
		end
	end

	// element and term counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
			r_q <= '0;
			c_q <= '0;
			e_q <= '0;
		end else begin
			if (cmd.start) begin
				k_q <= '0;
				r_q <= '0;
				c_q <= '0;
				e_q <= '0;
			end else begin
				if (cmd.issue) begin
					k_q <= k_last ? '0 : k_q + K_W'(1);
				end
				if (cmd.emit) begin
					e_q <= e_q + ADDR_W'(1);
					r_q <= r_last ? '0 : r_q + K_W'(1);
					if (r_last) begin
						c_q <= c_q + K_W'(1);
					end
				end
			end
		end
	end

	// unwritten entries read as zero
	assign opl = rdv_l_s1 ? signed'(rd_l_s1) : '0;
	assign opr = rdv_r_s1 ? signed'(rd_r_s1) : '0;

	always_ff @(posedge clk) begin
		prod_s2 <= opl * opr;
	end

	// arithmetic shift floors toward minus infinity; sign-extend the term
	assign prod_sh = prod_s2 >>> mm4_pkg::FRAC_W;
	assign term    = ACC_W'(signed'(prod_sh[SH_W-1:0]));

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			acc_q <= (first_s2 ? '0 : acc_q) + term;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			first_s1   <= 1'b0;
			lastk_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			first_s2   <= 1'b0;
			lastk_s2   <= 1'b0;
			acc_done_q <= 1'b0;
		end else begin
			valid_s1 <= cmd.issue;
			first_s1 <= (k_q == '0);
			lastk_s1 <= k_last;
			valid_s2 <= valid_s1;
			first_s2 <= first_s1;
			lastk_s2 <= lastk_s1;
			if (valid_s2 && lastk_s2) begin
				acc_done_q <= 1'b1;
			end else if (cmd.emit) begin
				acc_done_q <= 1'b0;
			end
		end
	end

	always_comb begin
		priority if (acc_q > SAT_MAX) begin
			sat_val = SAT_MAX[VAL_W-1:0];
		end else if (acc_q < SAT_MIN) begin
			sat_val = SAT_MIN[VAL_W-1:0];
		end else begin
			sat_val = acc_q[VAL_W-1:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_idx_q  <= e_wide[mm4_pkg::IDX_W-1:0];
			out_val_q  <= sat_val;
			out_last_q <= e_last;
		end
	end

	assign out_valid     = out_valid_q;
	assign product_index = out_idx_q;
	assign product_value = out_val_q;
	assign last          = out_last_q;

	always_comb begin
		stat          = '0;
		stat.k_last   = k_last;
		stat.e_last   = e_last;
		stat.acc_done = acc_done_q;
		stat.out_free = !out_valid_q || out_ready;
	end

`ifndef SYNTHESIS
	a_emit_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || out_ready))
		else $error("emit while output register is occupied");
	a_emit_needs_sum: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> acc_done_q)
		else $error("emit before sum is complete");
	a_no_load_in_compute: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> !(cmd.load_l || cmd.load_r || cmd.start))
		else $error("request taken during compute");
	a_sum_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && lastk_s2) |=> acc_done_q)
		else $error("completed sum not flagged");
`endif

endmodule
`default_nettype wire

[sim/matrix_4x4_multiply_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_4x4_multiply_top_tb
// Self-checking bench for the Q16.16 column-major matrix multiplier. Load and
// compute requests go in through a valid/ready source with random gaps. A
// bit-accurate predictor keeps its own copy of both matrices and queues the
// sixteen product elements of every compute. Each result taken at the output
// is checked against the oldest queued element. The sink stalls at random,
// and once holds off long enough to back the block up into its input.
// ----------------------------------------------------------------------------
module matrix_4x4_multiply_top_tb;

	localparam int DIM    = mm4_pkg::DIM;
	localparam int CELLS  = mm4_pkg::CELLS;
	localparam int CMD_W  = mm4_pkg::CMD_W;
	localparam int IDX_W  = mm4_pkg::IDX_W;
	localparam int VAL_W  = mm4_pkg::VAL_W;
	localparam int FRAC_W = mm4_pkg::FRAC_W;

	localparam logic [CMD_W-1:0] CMD_LOAD_LEFT  = mm4_pkg::CMD_LOAD_LEFT;
	localparam logic [CMD_W-1:0] CMD_LOAD_RIGHT = mm4_pkg::CMD_LOAD_RIGHT;
	localparam logic [CMD_W-1:0] CMD_COMPUTE    = mm4_pkg::CMD_COMPUTE;

	// the package only names the three live commands
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	localparam logic signed [VAL_W-1:0] Q_ONE = 32'sh0001_0000;
	localparam logic signed [VAL_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [VAL_W-1:0] Q_MIN = 32'sh8000_0000;
	localparam logic signed [VAL_W-1:0] Q_LSB = 32'sh0000_0001;
	localparam logic signed [VAL_W-1:0] Q_NEG_LSB = 32'shFFFF_FFFF;

	// random part: most of it with idling, a short quiet tail at the end
	localparam int RANDOM_ITEMS = 130;
	localparam int TAIL_ITEMS   = 40;
	localparam int LONG_HOLD    = 400;

	typedef struct packed {
		logic [IDX_W-1:0]        index;
		logic signed [VAL_W-1:0] value;
		logic                    last;
	} product_t;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_ready;
	logic [CMD_W-1:0]         command;
	logic [IDX_W-1:0]         element_index;
	logic signed [VAL_W-1:0]  element_value;
	logic                     out_valid;
	logic                     out_ready;
	logic [IDX_W-1:0]         product_index;
	logic signed [VAL_W-1:0]  product_value;
	logic                     last;

	// predictor state: shadow copies of both matrices
	logic signed [VAL_W-1:0]  left_elems  [CELLS];
	logic signed [VAL_W-1:0]  right_elems [CELLS];
	product_t                 expected_products [$];

	int  mismatch_count   = 0;
	int  requests_taken   = 0;
	bit  source_gaps      = 1'b1;
	bit  sink_stalls      = 1'b1;
	int  sink_hold_cycles = 0;

	matrix_4x4_multiply_top uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.command       (command),
		.element_index (element_index),
		.element_value (element_value),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.product_index (product_index),
		.product_value (product_value),
		.last          (last)
	);

	always #6 clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// Queue all product elements, column by column. Each term is the full
	// 64-bit product shifted right arithmetically, i.e. rounded toward minus
	// infinity; the four terms sum in 64 bits and clamp to 32 bits.
	task automatic predict_product();
		longint   acc;
		product_t elem;
		for (int c = 0; c < DIM; c++) begin
			for (int r = 0; r < DIM; r++) begin
				acc = 0;
				for (int k = 0; k < DIM; k++)
					acc += (longint'(left_elems[k * DIM + r]) *
						longint'(right_elems[c * DIM + k])) >>> FRAC_W;
				if (acc > 64'sd2147483647)
					elem.value = Q_MAX;
				else if (acc < -64'sd2147483648)
					elem.value = Q_MIN;
				else
					elem.value = VAL_W'(acc);
				elem.index = IDX_W'(c * DIM + r);
				elem.last  = (c == DIM - 1) && (r == DIM - 1);
				expected_products = {expected_products, elem};
			end
		end
	endtask

	// Apply one accepted request to the shadow state.
	task automatic apply_request(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
			input logic signed [VAL_W-1:0] val);
		case (cmd)
			CMD_LOAD_LEFT: begin
				if (idx < CELLS)
					left_elems[idx] = val;
			end
			CMD_LOAD_RIGHT: begin
				if (idx < CELLS)
					right_elems[idx] = val;
			end
			CMD_COMPUTE: predict_product();
			default: ;	// unused command: drop it
		endcase
		if (cmd != CMD_UNUSED)
			requests_taken++;
	endtask

	// ------------------------------------------------------------------
	// Request source
	// ------------------------------------------------------------------

	// Offer one request and hold it until the block takes it. Valid is left
	// high on return so back-to-back requests keep it up; an idle burst
	// drops it at the next falling edge.
	task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
			input logic signed [VAL_W-1:0] val);
		if (source_gaps && $urandom_range(0, 4) == 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat ($urandom_range(0, 7)) @(negedge clk);
		end
		@(negedge clk);
		in_valid      = 1'b1;
		command       = cmd;
		element_index = idx;
		element_value = val;
		do @(posedge clk); while (!in_ready);
		apply_request(cmd, idx, val);
	endtask

	// Compute ignores index and value, so let them wander.
	task automatic send_compute();
		send_request(CMD_COMPUTE, IDX_W'($urandom), VAL_W'($urandom));
	endtask

	// Mix of value classes: clamps, zero, unit, small signed, full random.
	function automatic logic signed [VAL_W-1:0] random_element();
		case ($urandom_range(0, 9))
			0: return Q_MAX;
			1: return Q_MIN;
			2: return '0;
			3: return $urandom_range(0, 1) ? Q_ONE : -Q_ONE;
			4, 5, 6: return VAL_W'($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
			default: return VAL_W'($urandom);
		endcase
	endfunction

	// One well-formed sequence: a full reload of the matrices, or a partial one
	// with the odd unused command mixed in, then a compute.
	task automatic run_sequence();
		if ($urandom_range(0, 4) == 0) begin
			for (int i = 0; i < CELLS; i++) begin
				send_request(CMD_LOAD_LEFT, IDX_W'(i), random_element());
				send_request(CMD_LOAD_RIGHT, IDX_W'(i), random_element());
			end
		end else begin
			repeat ($urandom_range(1, 12)) begin
				if ($urandom_range(0, 11) == 0)
					send_request(CMD_UNUSED, IDX_W'($urandom), VAL_W'($urandom));
				send_request($urandom_range(0, 1) ? CMD_LOAD_RIGHT : CMD_LOAD_LEFT,
					IDX_W'($urandom), random_element());
			end
		end
		send_compute();
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Both matrices come out of reset zeroed, so the product is all zero.
	task automatic test_reset_clears();
		send_compute();
	endtask

	// Identity on the left passes the right matrix through exactly, extremes
	// and the smallest negative value included.
	task automatic test_identity_extremes();
		for (int d = 0; d < DIM; d++)
			send_request(CMD_LOAD_LEFT, IDX_W'(d * (DIM + 1)), Q_ONE);
		send_request(CMD_LOAD_RIGHT, 4'd0, Q_MAX);
		send_request(CMD_LOAD_RIGHT, 4'd5, Q_MIN);
		send_request(CMD_LOAD_RIGHT, 4'd10, Q_NEG_LSB);
		send_request(CMD_LOAD_RIGHT, 4'd15, Q_LSB);
		send_compute();
	endtask

	// Clamp the sum both ways, and round a tiny negative product down to -1.
	task automatic test_saturation();
		send_request(CMD_LOAD_LEFT, 4'd0, Q_MAX);
		send_request(CMD_LOAD_LEFT, 4'd4, Q_MAX);
		send_request(CMD_LOAD_RIGHT, 4'd1, Q_MAX);
		send_request(CMD_LOAD_RIGHT, 4'd4, Q_MIN);
		send_request(CMD_LOAD_LEFT, 4'd15, Q_NEG_LSB);
		send_request(CMD_LOAD_RIGHT, 4'd15, Q_LSB);
		send_compute();
	endtask

	// The unused command must leave both matrices alone.
	task automatic test_unused_command();
		send_request(CMD_UNUSED, 4'd0, 32'sh1234_5678);
		send_request(CMD_UNUSED, 4'd15, Q_MIN);
		send_compute();
	endtask

	// Hold the sink off for a long stretch while requests keep coming, so the
	// output register fills and the block has to stall its input.
	task automatic test_output_backpressure();
		sink_hold_cycles = LONG_HOLD;
		send_compute();
		repeat (6)
			send_request($urandom_range(0, 1) ? CMD_LOAD_RIGHT : CMD_LOAD_LEFT,
				IDX_W'($urandom), random_element());
		send_compute();
	endtask

	task automatic test_random_sequences(input int item_goal);
		int goal;
		goal = requests_taken + item_goal;
		while (requests_taken < goal)
			run_sequence();
	endtask

	// Same traffic with both sides always ready.
	task automatic test_quiet_tail(input int item_goal);
		source_gaps = 1'b0;
		sink_stalls = 1'b0;
		test_random_sequences(item_goal);
	endtask

	// ------------------------------------------------------------------
	// Result sink: random stall bursts, plus one long hold on request
	// ------------------------------------------------------------------
	initial begin : result_sink
		int hold;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (sink_hold_cycles > 0) begin
				hold = sink_hold_cycles;
				sink_hold_cycles = 0;
				out_ready = 1'b0;
				// count the hold in cycles of its own
				for (int n = 1; n < hold; n++)
					@(negedge clk);
			end else if (sink_stalls && $urandom_range(0, 3) == 0) begin
				out_ready = 1'b0;
				repeat ($urandom_range(0, 7)) @(negedge clk);
			end else begin
				out_ready = 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Result checker: compare every taken result with the oldest expectation
	// ------------------------------------------------------------------
	always @(posedge clk) begin : check_results
		product_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_products.size() == 0) begin
				$error("unexpected result: product_index %0d product_value %0d last %0b",
					product_index, product_value, last);
				mismatch_count++;
			end else begin
				want = expected_products.pop_front();
				if (product_index !== want.index) begin
					$error("product_index mismatch: expected %0d, actual %0d",
						want.index, product_index);
					mismatch_count++;
				end
				if (product_value !== want.value) begin
					$error("product_value mismatch: expected %0d, actual %0d",
						want.value, product_value);
					mismatch_count++;
				end
				if (last !== want.last) begin
					$error("last mismatch: expected %0b, actual %0b", want.last, last);
					mismatch_count++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	initial begin : run_tests
		in_valid      = 1'b0;
		command       = CMD_LOAD_LEFT;
		element_index = '0;
		element_value = '0;
		arst_n        = 1'b0;
		foreach (left_elems[i]) begin
			left_elems[i]  = '0;
			right_elems[i] = '0;
		end

		// hold reset, then release it away from the clock edge
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_clears();
		test_identity_extremes();
		test_saturation();
		test_unused_command();
		test_output_backpressure();
		test_random_sequences(RANDOM_ITEMS);
		test_quiet_tail(TAIL_ITEMS);

		// drop valid, drain every expected element, then watch for strays
		@(negedge clk);
		in_valid = 1'b0;
		while (expected_products.size() != 0)
			@(posedge clk);
		repeat (DIM + 8) @(posedge clk);

		if (mismatch_count == 0)
			$display("matrix_4x4_multiply_top_tb OK");
		else
			$display("matrix_4x4_multiply_top_tb NOT OK");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin : watchdog
		#5_000_000;
		$display("matrix_4x4_multiply_top_tb NOT OK");
		$finish;
	end

endmodule

[filelist.f]
sv/mm4_pkg.sv
sv/mm4_ctrl.sv
sv/mm4_datapath.sv
sv/matrix_4x4_multiply_top.sv
sim/matrix_4x4_multiply_top_tb.sv
